// File: rtl/core/nibr_pkg.sv
// ----------------------------------------------------------------------------
// nibr_pkg
// Shared types and constants for the 4bpp packed raster engine.
// ----------------------------------------------------------------------------
package nibr_pkg;

	localparam int MAX_WIDTH       = 640;
	localparam int MAX_HEIGHT      = 480;
	localparam int MAX_GLYPH_WIDTH = 24;
	localparam int STORE_BYTES     = (MAX_WIDTH / 2) * MAX_HEIGHT;
	localparam int ADDR_W          = $clog2(STORE_BYTES);
	localparam int CALC_W          = 20;
	localparam int GLYPH_MSB       = 23;
	localparam int GLYPH_CAP       = (MAX_GLYPH_WIDTH < 24) ? (MAX_GLYPH_WIDTH & ~1) : 24;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_FILL  = 2'd1,
		REQ_GLYPH = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_ORDER = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		CFG_XRES   = 2'd0,
		CFG_YRES   = 2'd1,
		CFG_LINE   = 2'd2,
		CFG_GLYPHH = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DECIDE,
		S_ADDR,
		S_READ,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [9:0]  x;
		logic [8:0]  y;
		logic [9:0]  x_end;
		logic [8:0]  y_end;
		logic [3:0]  color;
		logic [3:0]  bg_color;
		logic [23:0] glyph_bits;
		logic [4:0]  glyph_width;
		logic [4:0]  glyph_row;
	} in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic clear_en;
		logic load_req;
		logic check;
		logic start;
		logic addr_en;
		logic read_en;
		logic write_en;
		logic step;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic last_pix;
	} stat_t;

endpackage

// File: rtl/core/nibr_ctrl.sv
// ----------------------------------------------------------------------------
// nibr_ctrl
// Sequencer: store clear after reset, request check, per-pixel
// read-modify-write loop and result hand-off.
// ----------------------------------------------------------------------------
module nibr_ctrl
	import nibr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output cmd_t  cmd,
	input  stat_t st
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (st.clr_last) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = S_CHECK;
			S_CHECK:  state_d = S_DECIDE;
			S_DECIDE: state_d = st.bad ? S_DONE : S_ADDR;
			S_ADDR:   state_d = S_READ;
			S_READ:   state_d = S_WRITE;
			S_WRITE:  state_d = st.last_pix ? S_DONE : S_ADDR;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clear_en = 1'b1;
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			S_CHECK: cmd.check = 1'b1;
			S_DECIDE: begin
				cmd.finish = st.bad;
				cmd.start  = !st.bad;
			end
			S_ADDR: cmd.addr_en = 1'b1;
			S_READ: cmd.read_en = 1'b1;
			S_WRITE: begin
				cmd.write_en = 1'b1;
				cmd.finish   = st.last_pix;
				cmd.step     = !st.last_pix;
			end
			S_DONE: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/nibr_dp.sv
// ----------------------------------------------------------------------------
// nibr_dp
// Datapath: configuration registers, bounds check, pixel walker, frame
// store with registered read and nibble merge.
// ----------------------------------------------------------------------------
module nibr_dp
	import nibr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  in_t        in_data,
	input  cmd_t       cmd,
	output stat_t      st,
	output out_t       out_data
);

	logic [7:0] mem [STORE_BYTES];

	logic [9:0]        xres_q;
	logic [8:0]        yres_q;
	logic [8:0]        line_q;
	logic [5:0]        gh_q;
	in_t               req_q;
	logic [ADDR_W-1:0] clr_q;
	logic [CALC_W-1:0] chk_addr_q;
	logic              cx_ok_q, cy_ok_q, gr_ok_q;
	logic [9:0]        px_q, py_q;
	logic [4:0]        gi_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        rdata_q;
	out_t              res_q, out_q;

	logic [4:0]        span;
	logic [10:0]       cx;
	logic [9:0]        cy;
	logic [9:0]        row;
	logic              range_ok;
	status_code_t      code;
	logic [3:0]        pix_color;
	logic [7:0]        merged;
	logic              is_read;
	logic              last_pix;

	assign is_read = (req_q.req_type == REQ_READ);
	assign row     = 10'(req_q.y) + 10'(req_q.glyph_row);

	always_comb begin
		if (req_q.glyph_width < 5'd12)
			span = 5'd8;
		else
			span = req_q.glyph_width & 5'b11100;
		if (span > 5'(GLYPH_CAP))
			span = 5'(GLYPH_CAP);
	end

	// the largest corner decides the range check; address grows in x and y
	always_comb begin
		case (req_q.req_type)
			REQ_FILL: begin
				cx = 11'((req_q.x > req_q.x_end) ? req_q.x : req_q.x_end);
				cy = 10'((req_q.y > req_q.y_end) ? req_q.y : req_q.y_end);
			end
			REQ_GLYPH: begin
				cx = 11'({req_q.x[9:1], 1'b0}) + 11'(span) - 11'd1;
				cy = row;
			end
			default: begin
				cx = 11'(req_q.x);
				cy = 10'(req_q.y);
			end
		endcase
	end

	always_comb begin
		range_ok = cx_ok_q && cy_ok_q && gr_ok_q &&
			(chk_addr_q < CALC_W'(STORE_BYTES));
		if (!range_ok)
			code = ST_RANGE;
		else if (req_q.req_type == REQ_FILL &&
			(req_q.x > req_q.x_end || req_q.y > req_q.y_end))
			code = ST_ORDER;
		else
			code = ST_DONE;
	end

	always_comb begin
		case (req_q.req_type)
			REQ_FILL:  last_pix = (px_q == req_q.x_end) && (py_q == 10'(req_q.y_end));
			REQ_GLYPH: last_pix = (gi_q == span - 5'd1);
			default:   last_pix = 1'b1;
		endcase
	end

	assign st.last_pix = last_pix;
	assign st.bad      = (code != ST_DONE);
	assign st.clr_last = (clr_q == ADDR_W'(STORE_BYTES - 1));

	always_comb begin
		if (req_q.req_type == REQ_GLYPH)
			pix_color = req_q.glyph_bits[5'(GLYPH_MSB) - gi_q] ? req_q.color : req_q.bg_color;
		else
			pix_color = req_q.color;
		merged = px_q[0] ? {rdata_q[7:4], pix_color} : {pix_color, rdata_q[3:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xres_q <= 10'd640;
			yres_q <= 9'd480;
			line_q <= 9'd320;
			gh_q   <= 6'd16;
			clr_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_XRES:   xres_q <= cfg_data;
					CFG_YRES:   yres_q <= cfg_data[8:0];
					CFG_LINE:   line_q <= cfg_data[8:0];
					CFG_GLYPHH: gh_q   <= cfg_data[5:0];
					default:    ;
				endcase
			end
			if (cmd.clear_en && !st.clr_last)
				clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req)
			req_q <= in_data;
		if (cmd.check) begin
			chk_addr_q <= CALC_W'(line_q * cy) + CALC_W'(cx[10:1]);
			cx_ok_q    <= cx < 11'(xres_q);
			cy_ok_q    <= cy < 10'(yres_q);
			gr_ok_q    <= (req_q.req_type != REQ_GLYPH) || (6'(req_q.glyph_row) < gh_q);
		end
		if (cmd.start) begin
			px_q <= (req_q.req_type == REQ_GLYPH) ? {req_q.x[9:1], 1'b0} : req_q.x;
			py_q <= (req_q.req_type == REQ_GLYPH) ? row : 10'(req_q.y);
			gi_q <= '0;
		end else if (cmd.step) begin
			if (req_q.req_type == REQ_FILL && px_q == req_q.x_end) begin
				px_q <= req_q.x;
				py_q <= py_q + 10'd1;
			end else begin
				px_q <= px_q + 10'd1;
			end
			gi_q <= gi_q + 5'd1;
		end
		if (cmd.addr_en)
			addr_q <= ADDR_W'(line_q * py_q) + ADDR_W'(px_q[9:1]);
		if (cmd.read_en)
			rdata_q <= mem[addr_q];
		if (cmd.finish) begin
			if (st.bad)
				res_q <= '{read_data: 8'd0, status: code};
			else
				res_q <= '{read_data: is_read ? rdata_q : 8'd0, status: ST_DONE};
		end
		if (cmd.out_load)
			out_q <= res_q;
	end

	// single write port: clear sweep or nibble merge
	always_ff @(posedge clk) begin
		if (cmd.clear_en)
			mem[clr_q] <= 8'd0;
		else if (cmd.write_en && !is_read)
			mem[addr_q] <= merged;
	end

	assign out_data = out_q;

endmodule

// File: rtl/core/nibble_packed_raster_engine.sv
// ----------------------------------------------------------------------------
// nibble_packed_raster_engine
// 4bpp packed frame store with put-pixel, rectangle fill, glyph row and
// byte read requests.
// ----------------------------------------------------------------------------
// Usage: one request beat on in_valid/in_ready gives one result beat on
// out_valid/out_ready (read_data, status). Registers are written through
// cfg_valid/cfg_ready with cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// After reset the frame store (STORE_BYTES, 153600 bytes) is swept to
// zero, one byte a cycle; no request is taken during the sweep. Each
// request passes the check and decide states; a flagged request then goes
// to the result, else every pixel takes an address, a read and a write
// step of the single-port read-modify-write of the frame store.
// A new request is taken in the cycle after the result enters the output
// register, also while a result waits; a stalled receiver holds the block
// once a second result is ready.
// ----------------------------------------------------------------------------
module nibble_packed_raster_engine
	import nibr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	nibr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	nibr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_en && cmd.write_en))
		else $error("clear and pixel write collide");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result overwrites pending beat");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result register load lost");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while busy");

endmodule
